FILE: rtl/triangle_flat_normal_assert.svh
// Assertion macros shared by the triangle face normal RTL.
// Files that check their own logic include this header; it needs clk and rst in scope.
`ifndef TRIANGLE_FLAT_NORMAL_ASSERT_SVH
`define TRIANGLE_FLAT_NORMAL_ASSERT_SVH

// Clocked assertion that is switched off while reset is held.
`define TFN_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same-cycle implication built on the macro above.
`define TFN_ASSERT_IMPL(label, pre, post, msg) \
  `TFN_ASSERT(label, pre |-> post, msg)

`endif

FILE: rtl/tfn_pkg.sv
// Package for the triangle face normal block: widths, constants and payload types.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package tfn_pkg;

  localparam int IdxW    = 32;
  localparam int CoordW  = 32;
  localparam int EdgeW   = 33;
  localparam int ProdW   = 66;
  localparam int CrossW  = 67;
  localparam int MagW    = 66;
  localparam int BlW     = 7;
  localparam int TopBits = 30;
  localparam int SqW     = 60;
  localparam int SumW    = 62;
  localparam int RootW   = 31;
  localparam int RemW    = 63;
  localparam int QuoW    = 15;
  localparam int NumW    = 46;
  localparam int DenW    = 32;
  localparam int NormW   = 16;

  localparam logic [NormW-1:0] OneQ14 = 16'd16384;

  // Data that rides alongside the arithmetic from the scaling stages to the output.
  typedef struct packed {
    logic [2:0][IdxW-1:0] idx;
    logic [2:0]           neg;
    logic                 degen;
  } tfn_side_t;

  typedef logic [2:0][TopBits-1:0] tfn_scaled_t;

endpackage

`default_nettype wire

FILE: rtl/tfn_cross.sv
// Edge and cross product stages: edges, six products, then component magnitudes and signs.
// Depends on tfn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tfn_cross (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  logic                                   in_valid,
  input  logic [2:0][tfn_pkg::IdxW-1:0]          idx_in,
  input  logic [2:0][tfn_pkg::CoordW-1:0]        corner_a,
  input  logic [2:0][tfn_pkg::CoordW-1:0]        corner_b,
  input  logic [2:0][tfn_pkg::CoordW-1:0]        corner_c,
  output logic                                   out_valid,
  output logic [2:0][tfn_pkg::IdxW-1:0]          idx_out,
  output logic [2:0][tfn_pkg::MagW-1:0]          mag,
  output logic [2:0]                             neg
);

  localparam int MagLen = tfn_pkg::MagW;

  logic                                  v1, v2, v3;
  logic [2:0][tfn_pkg::IdxW-1:0]         idx1, idx2;
  logic signed [tfn_pkg::EdgeW-1:0]      e1 [3];
  logic signed [tfn_pkg::EdgeW-1:0]      e2 [3];
  logic signed [tfn_pkg::ProdW-1:0]      prod [6];
  logic signed [tfn_pkg::CrossW-1:0]     cr [3];
  logic [2:0][tfn_pkg::MagW-1:0]         mag_c;
  logic [2:0]                            neg_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e1[i] <= $signed({corner_b[i][tfn_pkg::CoordW-1], corner_b[i]})
               - $signed({corner_a[i][tfn_pkg::CoordW-1], corner_a[i]});
        e2[i] <= $signed({corner_c[i][tfn_pkg::CoordW-1], corner_c[i]})
               - $signed({corner_a[i][tfn_pkg::CoordW-1], corner_a[i]});
      end
      idx1 <= idx_in;
      prod[0] <= e1[1] * e2[2];
      prod[1] <= e1[2] * e2[1];
      prod[2] <= e1[2] * e2[0];
      prod[3] <= e1[0] * e2[2];
      prod[4] <= e1[0] * e2[1];
      prod[5] <= e1[1] * e2[0];
      idx2 <= idx1;
      mag     <= mag_c;
      neg     <= neg_c;
      idx_out <= idx2;
    end
  end

  // Exact cross product, then sign and magnitude of each component.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cr[i] = $signed({prod[2*i][tfn_pkg::ProdW-1], prod[2*i]})
            - $signed({prod[2*i+1][tfn_pkg::ProdW-1], prod[2*i+1]});
      neg_c[i] = cr[i][tfn_pkg::CrossW-1];
      mag_c[i] = neg_c[i] ? MagLen'(-cr[i]) : cr[i][tfn_pkg::MagW-1:0];
    end
  end

  assign out_valid = v3;

endmodule

`default_nettype wire

FILE: rtl/tfn_scale.sv
// Scaling stages: bit length of the largest component, common shift to 30 bits,
// squares and their sum. Depends on tfn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tfn_scale (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic [2:0][tfn_pkg::IdxW-1:0]        idx_in,
  input  logic [2:0][tfn_pkg::MagW-1:0]        mag,
  input  logic [2:0]                           neg,
  output logic                                 out_valid,
  output tfn_pkg::tfn_side_t                   side_out,
  output tfn_pkg::tfn_scaled_t                 sm_out,
  output logic [tfn_pkg::SumW-1:0]             sum_out
);

  localparam int TopW = tfn_pkg::TopBits;
  localparam int BlLen = tfn_pkg::BlW;
  localparam int SumLen = tfn_pkg::SumW;

  logic                                 v4, v5, v6, v7;
  logic [tfn_pkg::MagW-1:0]             ormag;
  logic [tfn_pkg::BlW-1:0]              bl_c, bl4;
  logic [2:0][tfn_pkg::MagW-1:0]        mag4;
  tfn_pkg::tfn_side_t                   side4, side5, side6;
  tfn_pkg::tfn_scaled_t                 sm_c, sm5, sm6;
  logic [2:0][tfn_pkg::SqW-1:0]         sq6;

  always_comb begin
    ormag = mag[0] | mag[1] | mag[2];
    bl_c  = '0;
    for (int k = 0; k < tfn_pkg::MagW; k++) begin
      if (ormag[k]) begin
        bl_c = BlLen'(k + 1);
      end
    end
  end

  // Largest magnitude lands in [2^29, 2^30); right shifts truncate.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (bl4 > BlLen'(TopW)) begin
        sm_c[i] = TopW'(mag4[i] >> (bl4 - BlLen'(TopW)));
      end else begin
        sm_c[i] = TopW'(mag4[i] << (BlLen'(TopW) - bl4));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else if (en) begin
      v4 <= in_valid;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bl4         <= bl_c;
      mag4        <= mag;
      side4.idx   <= idx_in;
      side4.neg   <= neg;
      side4.degen <= (bl_c == '0);
      sm5   <= sm_c;
      side5 <= side4;
      for (int i = 0; i < 3; i++) begin
        sq6[i] <= sm5[i] * sm5[i];
      end
      sm6   <= sm5;
      side6 <= side5;
      sum_out  <= SumLen'(sq6[0]) + SumLen'(sq6[1]) + SumLen'(sq6[2]);
      sm_out   <= sm6;
      side_out <= side6;
    end
  end

  assign out_valid = v7;

endmodule

`default_nettype wire

FILE: rtl/tfn_isqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on tfn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tfn_isqrt (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic [tfn_pkg::SumW-1:0]             sum_in,
  input  tfn_pkg::tfn_side_t                   side_in,
  input  tfn_pkg::tfn_scaled_t                 sm_in,
  output logic                                 out_valid,
  output logic [tfn_pkg::RootW-1:0]            root_out,
  output tfn_pkg::tfn_side_t                   side_out,
  output tfn_pkg::tfn_scaled_t                 sm_out
);

  localparam int N = tfn_pkg::RootW;
  localparam int RemLen = tfn_pkg::RemW;

  logic [N-1:0]                  vq;
  logic [RemLen-1:0]             rem_q   [N];
  logic [N-1:0]                  root_q  [N];
  tfn_pkg::tfn_side_t            side_q  [N];
  tfn_pkg::tfn_scaled_t          sm_q    [N];
  logic [RemLen-1:0]             src_rem [N];
  logic [N-1:0]                  src_root[N];
  logic [RemLen-1:0]             trial   [N];

  // Stage j decides root bit N-1-j against (2*root + bit) * bit.
  always_comb begin
    src_rem[0]  = RemLen'(sum_in);
    src_root[0] = '0;
    for (int j = 1; j < N; j++) begin
      src_rem[j]  = rem_q[j-1];
      src_root[j] = root_q[j-1];
    end
    for (int j = 0; j < N; j++) begin
      trial[j] = (RemLen'(src_root[j]) << (N - j))
               | (RemLen'(1) << (2 * (N - 1 - j)));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vq <= '0;
    end else if (en) begin
      vq <= {vq[N-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < N; j++) begin
        if (src_rem[j] >= trial[j]) begin
          rem_q[j]  <= src_rem[j] - trial[j];
          root_q[j] <= src_root[j] | (N'(1) << (N - 1 - j));
        end else begin
          rem_q[j]  <= src_rem[j];
          root_q[j] <= src_root[j];
        end
      end
      side_q[0] <= side_in;
      sm_q[0]   <= sm_in;
      for (int j = 1; j < N; j++) begin
        side_q[j] <= side_q[j-1];
        sm_q[j]   <= sm_q[j-1];
      end
    end
  end

  assign out_valid = vq[N-1];
  assign root_out  = root_q[N-1];
  assign side_out  = side_q[N-1];
  assign sm_out    = sm_q[N-1];

endmodule

`default_nettype wire

FILE: rtl/tfn_div.sv
// Pipelined rounding divide of each scaled magnitude by the length, one quotient
// bit per stage, then clamp, sign and the degenerate override. Depends on tfn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tfn_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic [tfn_pkg::RootW-1:0]            root_in,
  input  tfn_pkg::tfn_side_t                   side_in,
  input  tfn_pkg::tfn_scaled_t                 sm_in,
  output logic                                 out_valid,
  output logic [2:0][tfn_pkg::IdxW-1:0]        idx_out,
  output logic [2:0][tfn_pkg::NormW-1:0]       normal,
  output logic                                 degen
);

  localparam int Q = tfn_pkg::QuoW;
  localparam int NumLen = tfn_pkg::NumW;
  localparam int NormLen = tfn_pkg::NormW;

  logic                                 v0, vout;
  logic [Q-1:0]                         vq;
  logic [2:0][NumLen-1:0]               num0;
  logic [tfn_pkg::DenW-1:0]             den0;
  tfn_pkg::tfn_side_t                   side0;
  logic [2:0][NumLen-1:0]               rem_q  [Q];
  logic [2:0][Q-1:0]                    quo_q  [Q];
  logic [tfn_pkg::DenW-1:0]             den_q  [Q];
  tfn_pkg::tfn_side_t                   side_q [Q];
  logic [2:0][NumLen-1:0]               src_rem[Q];
  logic [2:0][Q-1:0]                    src_quo[Q];
  logic [tfn_pkg::DenW-1:0]             src_den[Q];
  logic [NumLen-1:0]                    sub    [Q];
  logic [2:0][NormLen-1:0]              norm_c;
  logic [NormLen-1:0]                   mag_c;

  always_comb begin
    src_rem[0] = num0;
    src_quo[0] = '0;
    src_den[0] = den0;
    for (int j = 1; j < Q; j++) begin
      src_rem[j] = rem_q[j-1];
      src_quo[j] = quo_q[j-1];
      src_den[j] = den_q[j-1];
    end
    for (int j = 0; j < Q; j++) begin
      sub[j] = NumLen'(src_den[j]) << (Q - 1 - j);
    end
  end

  // Quotient never exceeds one in Q1.14, the clamp only guards the top code.
  always_comb begin
    mag_c = '0;
    for (int i = 0; i < 3; i++) begin
      mag_c = NormLen'(quo_q[Q-1][i]);
      if (mag_c > tfn_pkg::OneQ14) begin
        mag_c = tfn_pkg::OneQ14;
      end
      norm_c[i] = side_q[Q-1].neg[i] ? (NormLen'(0) - mag_c) : mag_c;
    end
    if (side_q[Q-1].degen) begin
      norm_c[0] = '0;
      norm_c[1] = tfn_pkg::OneQ14;
      norm_c[2] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0   <= 1'b0;
      vq   <= '0;
      vout <= 1'b0;
    end else if (en) begin
      v0   <= in_valid;
      vq   <= {vq[Q-2:0], v0};
      vout <= vq[Q-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        num0[i] <= (NumLen'(sm_in[i]) << Q) + NumLen'(root_in);
      end
      den0  <= {root_in, 1'b0};
      side0 <= side_in;
      for (int j = 0; j < Q; j++) begin
        for (int i = 0; i < 3; i++) begin
          if (src_rem[j][i] >= sub[j]) begin
            rem_q[j][i] <= src_rem[j][i] - sub[j];
            quo_q[j][i] <= {src_quo[j][i][Q-2:0], 1'b1};
          end else begin
            rem_q[j][i] <= src_rem[j][i];
            quo_q[j][i] <= {src_quo[j][i][Q-2:0], 1'b0};
          end
        end
        den_q[j] <= src_den[j];
      end
      side_q[0] <= side0;
      for (int j = 1; j < Q; j++) begin
        side_q[j] <= side_q[j-1];
      end
      normal  <= norm_c;
      idx_out <= side_q[Q-1].idx;
      degen   <= side_q[Q-1].degen;
    end
  end

  assign out_valid = vout;

endmodule

`default_nettype wire

FILE: rtl/triangle_flat_normal.sv
// Top level of the triangle face normal block: stream ports and the pipeline chain.
// Depends on tfn_pkg, tfn_cross, tfn_scale, tfn_isqrt, tfn_div and the assert header.
//
// Usage. One beat on the slave channel carries one triangle: three vertex
// indices and nine signed Q16.16 corner coordinates. One beat on the master
// channel carries the result: the indices unchanged, the unit face normal as
// three signed Q1.14 components rounded to nearest, and in tuser a flag that
// is set when the cross product is zero and the up vector (0,1,0) is given.
// Every triangle gives exactly one result, and results keep input order.
// An accepted input beat passes through the edge and cross product stages, the
// scaling and sum of squares stages, the square root (one bit per stage), and
// the rounding divide and output register before its result beat appears.
// Throughput is one triangle per cycle while the receiver takes the results;
// the depth of the square root and divider sets the latency, not the rate.
// The whole pipeline advances together: when the output register holds a beat
// that the receiver does not take, every stage holds and s_tready drops, so
// nothing is lost or repeated. Reset clears all valid bits at once; the block
// accepts a beat in the first cycle after reset is released.
`timescale 1ns / 1ps
`default_nettype none
`include "triangle_flat_normal_assert.svh"

module triangle_flat_normal (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // From bit 0 up: vertex_a_index, vertex_b_index, vertex_c_index,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z (32 bits each).
  input  logic [383:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // From bit 0 up: out_index_a, out_index_b, out_index_c (32 bits each),
  // normal_x, normal_y, normal_z (16 bits each).
  output logic [143:0] m_tdata,
  // Bit 0: degenerate.
  output logic [0:0]   m_tuser
);

  logic                                   en;
  logic [2:0][tfn_pkg::IdxW-1:0]          idx_in;
  logic [2:0][tfn_pkg::CoordW-1:0]        corner_a, corner_b, corner_c;

  logic                                   cross_valid;
  logic [2:0][tfn_pkg::IdxW-1:0]          cross_idx;
  logic [2:0][tfn_pkg::MagW-1:0]          cross_mag;
  logic [2:0]                             cross_neg;

  logic                                   scale_valid;
  tfn_pkg::tfn_side_t                     scale_side;
  tfn_pkg::tfn_scaled_t                   scale_sm;
  logic [tfn_pkg::SumW-1:0]               scale_sum;

  logic                                   sqrt_valid;
  logic [tfn_pkg::RootW-1:0]              sqrt_root;
  tfn_pkg::tfn_side_t                     sqrt_side;
  tfn_pkg::tfn_scaled_t                   sqrt_sm;

  logic [2:0][tfn_pkg::IdxW-1:0]          out_idx;
  logic [2:0][tfn_pkg::NormW-1:0]         out_normal;
  logic                                   out_degen;

  // The pipeline moves whenever the output register is empty or being drained.
  // No beat is taken while reset is held, since the valid bits are being cleared.
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en && !rst;

  assign idx_in[0]   = s_tdata[31:0];
  assign idx_in[1]   = s_tdata[63:32];
  assign idx_in[2]   = s_tdata[95:64];
  assign corner_a[0] = s_tdata[127:96];
  assign corner_a[1] = s_tdata[159:128];
  assign corner_a[2] = s_tdata[191:160];
  assign corner_b[0] = s_tdata[223:192];
  assign corner_b[1] = s_tdata[255:224];
  assign corner_b[2] = s_tdata[287:256];
  assign corner_c[0] = s_tdata[319:288];
  assign corner_c[1] = s_tdata[351:320];
  assign corner_c[2] = s_tdata[383:352];

  tfn_cross u_cross (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .idx_in    (idx_in),
    .corner_a  (corner_a),
    .corner_b  (corner_b),
    .corner_c  (corner_c),
    .out_valid (cross_valid),
    .idx_out   (cross_idx),
    .mag       (cross_mag),
    .neg       (cross_neg)
  );

  tfn_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (cross_valid),
    .idx_in    (cross_idx),
    .mag       (cross_mag),
    .neg       (cross_neg),
    .out_valid (scale_valid),
    .side_out  (scale_side),
    .sm_out    (scale_sm),
    .sum_out   (scale_sum)
  );

  tfn_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (scale_valid),
    .sum_in    (scale_sum),
    .side_in   (scale_side),
    .sm_in     (scale_sm),
    .out_valid (sqrt_valid),
    .root_out  (sqrt_root),
    .side_out  (sqrt_side),
    .sm_out    (sqrt_sm)
  );

  tfn_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sqrt_valid),
    .root_in   (sqrt_root),
    .side_in   (sqrt_side),
    .sm_in     (sqrt_sm),
    .out_valid (m_tvalid),
    .idx_out   (out_idx),
    .normal    (out_normal),
    .degen     (out_degen)
  );

  assign m_tdata = {out_normal[2], out_normal[1], out_normal[0],
                    out_idx[2], out_idx[1], out_idx[0]};
  assign m_tuser = out_degen;

  // True when a Q1.14 component lies within plus or minus one.
  function automatic logic in_unit(input logic [tfn_pkg::NormW-1:0] v);
    return ($signed(v) <= 16'sd16384) && ($signed(v) >= -16'sd16384);
  endfunction

  // A degenerate triangle always carries exactly the up vector.
  `TFN_ASSERT_IMPL(a_degen_up, m_tvalid && out_degen, out_normal == 48'h4000_0000, "no up normal")

  // A real triangle never produces an all-zero normal.
  `TFN_ASSERT_IMPL(a_nonzero, m_tvalid && !out_degen, out_normal != '0, "zero normal")

  // Every component stays within plus or minus one in Q1.14.
  `TFN_ASSERT_IMPL(a_range_x, m_tvalid, in_unit(out_normal[0]), "normal x out of range")
  `TFN_ASSERT_IMPL(a_range_y, m_tvalid, in_unit(out_normal[1]), "normal y out of range")
  `TFN_ASSERT_IMPL(a_range_z, m_tvalid, in_unit(out_normal[2]), "normal z out of range")

endmodule

`default_nettype wire

FILE: test/testbench.sv
// Self-checking testbench for triangle_flat_normal: directed table, then random triangles.
// Depends on the RTL of the block (tfn_pkg and the top level); reads no files.
`timescale 1ns / 1ps

module testbench;

  // One triangle as it travels on the slave channel. Word 0 sits in the lowest
  // bits: the three indices, then a, b and c, each as x, y, z.
  typedef logic [11:0][31:0] tri_beat_t;

  // The expected contents of one result beat.
  typedef struct packed {
    logic [2:0][31:0] idx;
    logic [2:0][15:0] nrm;
    logic             degen;
  } face_normal_t;

  // One directed row. The typed-in normal is used only where typed is set.
  typedef struct {
    tri_beat_t    beat;
    logic         typed;
    face_normal_t want;
  } tri_row_t;

  localparam int PeriodNs = 10;
  localparam int Latency  = 55;
  localparam int RandomTriangles = 1100;
  localparam longint CycleLimit = 600000;

  localparam logic [31:0] Q16One  = 32'h0001_0000;
  localparam logic [31:0] Q16Max  = 32'h7fff_ffff;
  localparam logic [31:0] Q16Min  = 32'h8000_0000;
  localparam logic [15:0] Q14One  = 16'd16384;
  localparam logic [15:0] Q14MOne = 16'hc000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [383:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [143:0] m_tdata;
  logic [0:0]   m_tuser;

  face_normal_t pending_normals[$];
  int           error_count = 0;
  longint       cycle_count = 0;
  int           idle_pct = 0;   // chance in a hundred that the sender rests a cycle
  int           stall_pct = 0;  // chance in a hundred that the receiver stalls a cycle
  int           hold_cycles = 0; // long receiver hold-off, counted down below
  tri_row_t     rows[$];

  always #(PeriodNs / 2) clk = ~clk;

  triangle_flat_normal u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Integer square root, floor, one result bit per pass.
  function automatic logic [63:0] floor_sqrt(input logic [63:0] s);
    logic [63:0] root;
    logic [63:0] bit_w;
    root  = '0;
    bit_w = 64'd1 << 62;
    while (bit_w > s) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (s >= root + bit_w) begin
        s    = s - (root + bit_w);
        root = (root >> 1) + bit_w;
      end else begin
        root = root >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return root;
  endfunction

  // Predicts the result beat of one triangle. The edges and the cross product
  // are exact in 128-bit signed arithmetic; the largest magnitude is then
  // brought into [2^29, 2^30) and every component is divided by the length
  // with rounding to nearest, ties away from zero.
  function automatic face_normal_t face_normal(input tri_beat_t t);
    face_normal_t       r;
    logic signed [127:0] e1 [3];
    logic signed [127:0] e2 [3];
    logic signed [127:0] cr [3];
    logic        [127:0] mag [3];
    logic        [63:0]  sm [3];
    logic        [63:0]  sum_sq;
    logic        [63:0]  len;
    logic        [63:0]  q;
    int                  top_bit;
    int                  shift;
    for (int i = 0; i < 3; i++) begin
      e1[i] = 128'(signed'(t[6 + i])) - 128'(signed'(t[3 + i]));
      e2[i] = 128'(signed'(t[9 + i])) - 128'(signed'(t[3 + i]));
    end
    cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
    cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
    cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
    r.idx   = {t[2], t[1], t[0]};
    r.degen = 1'b0;
    top_bit = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = cr[i] < 0 ? -cr[i] : cr[i];
      for (int b = 0; b < 128; b++)
        if (mag[i][b] && b + 1 > top_bit) top_bit = b + 1;
    end
    if (top_bit == 0) begin
      r.nrm   = {16'd0, Q14One, 16'd0};
      r.degen = 1'b1;
      return r;
    end
    shift  = top_bit - 30;
    sum_sq = '0;
    for (int i = 0; i < 3; i++) begin
      sm[i]  = shift >= 0 ? 64'(mag[i] >> shift) : 64'(mag[i] << (-shift));
      sum_sq = sum_sq + sm[i] * sm[i];
    end
    len = floor_sqrt(sum_sq);
    for (int i = 0; i < 3; i++) begin
      q = (64'd32768 * sm[i] + len) / (64'd2 * len);
      if (q > 64'd16384) q = 64'd16384;
      if (cr[i] < 0) q = -q;
      r.nrm[i] = q[15:0];
    end
    return r;
  endfunction

  function automatic tri_beat_t make_beat(input logic [2:0][31:0] idx,
                                          input logic [2:0][31:0] a,
                                          input logic [2:0][31:0] b,
                                          input logic [2:0][31:0] c);
    return {c, b, a, idx};
  endfunction

  function automatic face_normal_t typed_normal(input tri_beat_t t, input logic [15:0] nx,
                                                input logic [15:0] ny, input logic [15:0] nz,
                                                input logic deg);
    face_normal_t r;
    r.idx   = {t[2], t[1], t[0]};
    r.nrm   = {nz, ny, nx};
    r.degen = deg;
    return r;
  endfunction

  // Appends one directed row to the stimulus table.
  task automatic add_row(input tri_beat_t beat, input logic typed, input face_normal_t want);
    tri_row_t r;
    r.beat  = beat;
    r.typed = typed;
    r.want  = want;
    rows.insert(rows.size(), r);
  endtask

  task automatic report(input string what, input logic [144:0] got, input logic [144:0] want);
    $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
    error_count++;
  endtask

  // Puts one triangle on the slave channel and holds it until the block takes
  // it. Valid is never lowered after a beat unless the sender chooses to rest,
  // so there is only one assignment to it in any time step.
  task automatic send_triangle(input tri_beat_t t, input logic typed, input face_normal_t want);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= t;
    do @(posedge clk); while (!s_tready);
    if (typed && want != face_normal(t))
      report("typed row disagrees with the predictor", face_normal(t), want);
    pending_normals.insert(pending_normals.size(), typed ? want : face_normal(t));
  endtask

  function automatic logic [31:0] rand_coord(input int kind);
    case (kind)
      0:       return $urandom();
      1:       return 32'(signed'(32'($urandom_range(2 * 65536 * 8)) - 65536 * 8));
      default: return 32'(signed'(32'($urandom_range(64)) - 32));
    endcase
  endfunction

  // Random triangles: mostly full-range or modest coordinates, a share of
  // tiny ones, and some degenerate cases with repeated or collinear corners.
  task automatic send_random_triangle();
    logic [2:0][31:0] idx;
    logic [2:0][31:0] a;
    logic [2:0][31:0] b;
    logic [2:0][31:0] c;
    int               kind;
    int               shape;
    face_normal_t     none;
    none  = '0;
    kind  = $urandom_range(2);
    shape = $urandom_range(19);
    for (int i = 0; i < 3; i++) begin
      idx[i] = $urandom();
      a[i]   = rand_coord(kind);
      b[i]   = rand_coord(kind);
      c[i]   = rand_coord(kind);
    end
    if (shape == 0) c = a;
    else if (shape == 1) c = b;
    else if (shape == 2) begin
      // c = a + 2 * (b - a) gives three corners on one line.
      for (int i = 0; i < 3; i++) begin
        b[i] = rand_coord(2);
        c[i] = b[i] + b[i] - a[i];
      end
    end
    send_triangle(make_beat(idx, a, b, c), 1'b0, none);
  endtask

  // Receiver side: random stalls, overridden by the long hold-off.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_tready    <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Result checker: every accepted result beat is compared field by field
  // with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_normals.size() == 0) begin
        report("result with nothing expected", {m_tuser, m_tdata}, '0);
      end else begin
        face_normal_t want;
        want = pending_normals.pop_front();
        for (int i = 0; i < 3; i++) begin
          if (m_tdata[32 * i +: 32] != want.idx[i])
            report("vertex index", 145'(m_tdata[32 * i +: 32]), 145'(want.idx[i]));
          if (m_tdata[96 + 16 * i +: 16] != want.nrm[i])
            report("normal component", 145'(m_tdata[96 + 16 * i +: 16]),
                   145'(want.nrm[i]));
        end
        if (m_tuser[0] != want.degen)
          report("degenerate flag", 145'(m_tuser[0]), 145'(want.degen));
      end
    end
  end

  // Watchdog: ends a run that has hung.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    tri_beat_t t;
    logic [2:0][31:0] ones;
    logic [2:0][31:0] zeros;
    int waited;
    ones  = {3{32'hffff_ffff}};
    zeros = '0;

    // All corners at the origin: zero cross product, up vector returned.
    t = make_beat(zeros, zeros, zeros, zeros);
    add_row(t, 1'b1, typed_normal(t, 16'd0, Q14One, 16'd0, 1'b1));
    // Unit triangle in the xy plane, counterclockwise: normal is +z.
    t = make_beat(ones, zeros, {32'd0, 32'd0, Q16One}, {32'd0, Q16One, 32'd0});
    add_row(t, 1'b1, typed_normal(t, 16'd0, 16'd0, Q14One, 1'b0));
    // Same triangle wound the other way: normal is -z.
    t = make_beat({32'd3, 32'd2, 32'd1}, zeros, {32'd0, Q16One, 32'd0},
                  {32'd0, 32'd0, Q16One});
    add_row(t, 1'b1, typed_normal(t, 16'd0, 16'd0, Q14MOne, 1'b0));
    // Triangle in the yz plane: normal is +x.
    t = make_beat(zeros, zeros, {32'd0, Q16One, 32'd0}, {Q16One, 32'd0, 32'd0});
    add_row(t, 1'b1, typed_normal(t, Q14One, 16'd0, 16'd0, 1'b0));
    // Triangle in the zx plane, wound to give -y.
    t = make_beat(zeros, zeros, {32'd0, 32'd0, Q16One}, {Q16One, 32'd0, 32'd0});
    add_row(t, 1'b1, typed_normal(t, 16'd0, Q14MOne, 16'd0, 1'b0));
    // Collinear corners and a repeated corner are degenerate too.
    t = make_beat(ones, {3{Q16Max}}, {3{Q16Min}}, {3{32'd5}});
    add_row(t, 1'b1, typed_normal(t, 16'd0, Q14One, 16'd0, 1'b1));
    t = make_beat(zeros, {3{Q16Min}}, {3{Q16Min}}, {3{Q16Max}});
    add_row(t, 1'b1, typed_normal(t, 16'd0, Q14One, 16'd0, 1'b1));
    // Coordinate extremes: widest edges and the largest cross products.
    t = make_beat(ones, {3{Q16Min}}, {Q16Min, Q16Min, Q16Max}, {Q16Min, Q16Max, Q16Min});
    add_row(t, 1'b0, '0);
    t = make_beat(zeros, {3{Q16Max}}, {Q16Max, Q16Max, Q16Min}, {Q16Max, Q16Min, Q16Max});
    add_row(t, 1'b0, '0);
    t = make_beat(ones, {Q16Min, Q16Max, Q16Min}, {Q16Max, Q16Min, Q16Max},
                  {Q16Max, Q16Max, Q16Min});
    add_row(t, 1'b0, '0);
    // Smallest possible edges: a cross product of magnitude one.
    t = make_beat({32'd7, 32'd6, 32'd5}, zeros, {32'd0, 32'd0, 32'd1}, {32'd0, 32'd1, 32'd0});
    add_row(t, 1'b1, typed_normal(t, 16'd0, 16'd0, Q14One, 1'b0));
    // Slanted tiny triangles, where rounding of the components matters.
    t = make_beat(zeros, zeros, {32'd0, 32'd1, 32'd1}, {32'd1, 32'd0, 32'd1});
    add_row(t, 1'b0, '0);
    t = make_beat(ones, {3{32'hffff_ffff}}, {32'd2, 32'd0, 32'd3}, {32'd1, 32'd4, 32'd0});
    add_row(t, 1'b0, '0);
    t = make_beat({32'h8000_0000, 32'h7fff_ffff, 32'h5555_aaaa},
                  {32'h0012_3456, 32'hffed_cba9, 32'h0001_8000},
                  {32'h0100_0000, 32'h0003_0000, 32'hfff0_0000},
                  {32'h7000_0000, 32'h9000_0000, 32'h0000_0001});
    add_row(t, 1'b0, '0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) send_triangle(rows[i].beat, rows[i].typed, rows[i].want);

    // Four traffic phases. During the first one the receiver holds off for a
    // long stretch while triangles keep coming, so the pipe fills and the
    // input stalls.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 76; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 76; end
        default: begin idle_pct = 9; stall_pct = 9; end
      endcase
      if (phase == 0) hold_cycles = 300;
      for (int n = 0; n < RandomTriangles / 4; n++) send_random_triangle();
    end
    s_tvalid <= 1'b0;

    waited = 0;
    while (pending_normals.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (2 * Latency) @(posedge clk);

    if (error_count == 0 && pending_normals.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/tfn_pkg.sv
rtl/tfn_cross.sv
rtl/tfn_scale.sv
rtl/tfn_isqrt.sv
rtl/tfn_div.sv
rtl/triangle_flat_normal.sv
test/testbench.sv
